// ----- rtl/core/linked_list_pool_manager_unit_defines.svh -----
// assertion helpers for the pool manager
`ifndef LINKED_LIST_POOL_MANAGER_UNIT_DEFINES_SVH
`define LINKED_LIST_POOL_MANAGER_UNIT_DEFINES_SVH

// implication into the next cycle
`define LLPM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("llpm check failed");

// invariant that holds at every edge
`define LLPM_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("llpm check failed");

`endif

// ----- rtl/core/llpm_pkg.sv -----
package llpm_pkg;

  localparam int NODES_DEF     = 64;
  localparam int LISTS_DEF     = 8;
  localparam int ITEM_BITS_DEF = 32;

  localparam logic [3:0] CMD_CREATE     = 4'd0;
  localparam logic [3:0] CMD_COUNT      = 4'd1;
  localparam logic [3:0] CMD_FIRST      = 4'd2;
  localparam logic [3:0] CMD_LAST       = 4'd3;
  localparam logic [3:0] CMD_NEXT       = 4'd4;
  localparam logic [3:0] CMD_PREV       = 4'd5;
  localparam logic [3:0] CMD_CURRENT    = 4'd6;
  localparam logic [3:0] CMD_INS_AFTER  = 4'd7;
  localparam logic [3:0] CMD_INS_BEFORE = 4'd8;
  localparam logic [3:0] CMD_APPEND     = 4'd9;
  localparam logic [3:0] CMD_PREPEND    = 4'd10;
  localparam logic [3:0] CMD_REMOVE     = 4'd11;
  localparam logic [3:0] CMD_TRIM       = 4'd12;
  localparam logic [3:0] CMD_CONCAT     = 4'd13;
  localparam logic [3:0] CMD_FREE       = 4'd14;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic item;
    logic nxt;
    logic prv;
  } node_we_t;

endpackage

// ----- rtl/core/llpm_node_mem.sv -----
module llpm_node_mem #(
  parameter int NODES     = llpm_pkg::NODES_DEF,
  parameter int ITEM_BITS = llpm_pkg::ITEM_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         re,
  input  logic [$clog2(NODES)-1:0]     raddr,
  input  llpm_pkg::node_we_t           we,
  input  logic [$clog2(NODES)-1:0]     waddr,
  input  logic [ITEM_BITS-1:0]         witem,
  input  logic [$clog2(NODES+1)-1:0]   wnext,
  input  logic [$clog2(NODES+1)-1:0]   wprev,
  output logic [ITEM_BITS-1:0]         ritem,
  output logic [$clog2(NODES+1)-1:0]   rnext,
  output logic [$clog2(NODES+1)-1:0]   rprev
);

  localparam int PW = $clog2(NODES + 1);

  logic [ITEM_BITS-1:0] mem_item [NODES];
  logic [PW-1:0]        mem_next [NODES];
  logic [PW-1:0]        mem_prev [NODES];

  always_ff @(posedge clk) begin
    if (we.item) begin
      mem_item[waddr] <= witem;
    end
    if (we.nxt) begin
      mem_next[waddr] <= wnext;
    end
    if (we.prv) begin
      mem_prev[waddr] <= wprev;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      ritem <= mem_item[raddr];
      rnext <= mem_next[raddr];
      rprev <= mem_prev[raddr];
    end
  end

endmodule

// ----- rtl/core/llpm_ring.sv -----
module llpm_ring #(
  parameter int NODES = llpm_pkg::NODES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [$clog2(NODES)-1:0] raddr,
  input  logic                     we,
  input  logic [$clog2(NODES)-1:0] waddr,
  input  logic [$clog2(NODES)-1:0] wdata,
  output logic [$clog2(NODES)-1:0] rdata
);

  localparam int IW = $clog2(NODES);

  logic [IW-1:0] mem [NODES];
  logic [NODES-1:0] valid;
  logic [IW-1:0] mem_q;
  logic [IW-1:0] addr_q;
  logic          valid_q;

  // unwritten entries read as their own index
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q   <= mem[raddr];
    valid_q <= valid[raddr];
    addr_q  <= raddr;
  end

  assign rdata = valid_q ? mem_q : addr_q;

endmodule

// ----- rtl/core/linked_list_pool_manager_unit.sv -----
// Pool manager for up to LISTS doubly linked lists sharing NODES nodes.
// Command channel: drive cmd, list_id, other_list and item with start high;
// the request is taken at the edge where start is high and busy is low.
// Busy stays high while the request is worked; exactly one result follows.
// Result channel: done is high for one cycle with status, item_out,
// length_out and new_list; the receiver cannot stall, so sample it then.
// Create, count and requests that find nothing end after dispatch; first, last,
// current, and next and prev from an empty cursor add an item read; other
// next and prev read a link first. Inserts write the new node, remove and
// trim take in the read node, then each writes up to two neighbour links;
// concat links two lists and frees a handle, only the handle for a list with
// itself; free walks every node back to the pool. All node links and items
// sit in one single-port-read node memory with a registered read, and each
// list edit is a read, then one write per touched node. A new request can be
// taken in the cycle done is high. Reset (rst, synchronous) empties all lists
// and refills both free rings, so the block is ready with no clearing pass.
`include "linked_list_pool_manager_unit_defines.svh"

module linked_list_pool_manager_unit #(
  parameter int NODES     = llpm_pkg::NODES_DEF,
  parameter int LISTS     = llpm_pkg::LISTS_DEF,
  parameter int ITEM_BITS = llpm_pkg::ITEM_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       start,
  output logic                                       busy,
  input  logic [3:0]                                 cmd,
  input  logic [((LISTS > 1) ? $clog2(LISTS) : 1)-1:0] list_id,
  input  logic [((LISTS > 1) ? $clog2(LISTS) : 1)-1:0] other_list,
  input  logic [ITEM_BITS-1:0]                       item,
  output logic                                       done,
  output logic [1:0]                                 status,
  output logic [ITEM_BITS-1:0]                       item_out,
  output logic [$clog2(NODES+1)-1:0]                 length_out,
  output logic [((LISTS > 1) ? $clog2(LISTS) : 1)-1:0] new_list
);

  localparam int PW  = $clog2(NODES + 1);
  localparam int IW  = $clog2(NODES);
  localparam int LW  = (LISTS > 1) ? $clog2(LISTS) : 1;
  localparam int LCW = $clog2(LISTS + 1);
  localparam logic [PW-1:0] NULLP = PW'(NODES);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_NX    = 4'd2;
  localparam logic [3:0] S_GOT   = 4'd3;
  localparam logic [3:0] S_ALLOC = 4'd4;
  localparam logic [3:0] S_RM1   = 4'd5;
  localparam logic [3:0] S_W1    = 4'd6;
  localparam logic [3:0] S_W2    = 4'd7;
  localparam logic [3:0] S_FREE  = 4'd8;
  localparam logic [3:0] S_CAT   = 4'd9;
  localparam logic [3:0] S_REL   = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0] state;

  logic [3:0]           cmd_r;
  logic [LW-1:0]        lr;
  logic [LW-1:0]        mr;
  logic [ITEM_BITS-1:0] item_r;
  logic [1:0]           stat_r;
  logic [ITEM_BITS-1:0] got_r;
  logic [LW-1:0]        newl_r;
  logic [PW-1:0]        ptr_r;
  logic [PW-1:0]        sav_tl;
  logic [PW-1:0]        sav_ln;

  logic          w1_en, w1_prv, w2_en, w2_prv;
  logic [IW-1:0] w1_addr, w2_addr;
  logic [PW-1:0] w1_val, w2_val;

  logic [PW-1:0] lhead [LISTS];
  logic [PW-1:0] ltail [LISTS];
  logic [PW-1:0] lcur  [LISTS];
  logic [PW-1:0] llen  [LISTS];
  logic          lpe   [LISTS];
  logic [LW-1:0] flring [LISTS];
  logic [LW-1:0] flrd, flwr;
  logic [LCW-1:0] lused;

  logic [IW-1:0] fnrd, fnwr;
  logic [PW-1:0] nused;

  logic [LW-1:0] lsel;
  logic [PW-1:0] hd, tl, cu, ln;
  logic          pe;
  logic          past_tail, pre_head, ins_tail, ins_head;
  logic [PW-1:0] n_p;

  logic                 n_re;
  logic [IW-1:0]        n_raddr;
  llpm_pkg::node_we_t   n_we;
  logic [IW-1:0]        n_waddr;
  logic [PW-1:0]        n_wnext, n_wprev;
  logic [ITEM_BITS-1:0] rd_item;
  logic [PW-1:0]        rd_next, rd_prev;

  logic          r_we;
  logic [IW-1:0] ring_n;

  logic [LW-1:0] lid_in, mid_in;

  assign lid_in = ({1'b0, list_id} >= (LW + 1)'(LISTS)) ?
                  LW'({1'b0, list_id} - (LW + 1)'(LISTS)) : list_id;
  assign mid_in = ({1'b0, other_list} >= (LW + 1)'(LISTS)) ?
                  LW'({1'b0, other_list} - (LW + 1)'(LISTS)) : other_list;

  assign busy = (state != S_IDLE);
  assign lsel = (state == S_CAT || state == S_REL) ? mr : lr;
  assign hd   = lhead[lsel];
  assign tl   = ltail[lsel];
  assign cu   = lcur[lsel];
  assign ln   = llen[lsel];
  assign pe   = lpe[lsel];
  assign n_p  = PW'(ring_n);

  assign past_tail = (cu == tl) || (cu == NULLP && pe);
  assign pre_head  = (cu == hd) || (cu == NULLP && !pe);
  assign ins_tail  = (cmd_r == llpm_pkg::CMD_APPEND) ||
                     (cmd_r == llpm_pkg::CMD_INS_AFTER && past_tail) ||
                     (cmd_r == llpm_pkg::CMD_INS_BEFORE && !pre_head && cu == NULLP);
  assign ins_head  = (cmd_r == llpm_pkg::CMD_PREPEND) ||
                     (cmd_r == llpm_pkg::CMD_INS_AFTER && !past_tail && cu == NULLP) ||
                     (cmd_r == llpm_pkg::CMD_INS_BEFORE && pre_head);

  llpm_node_mem #(
    .NODES     (NODES),
    .ITEM_BITS (ITEM_BITS)
  ) u_node_mem (
    .clk   (clk),
    .re    (n_re),
    .raddr (n_raddr),
    .we    (n_we),
    .waddr (n_waddr),
    .witem (item_r),
    .wnext (n_wnext),
    .wprev (n_wprev),
    .ritem (rd_item),
    .rnext (rd_next),
    .rprev (rd_prev)
  );

  llpm_ring #(
    .NODES (NODES)
  ) u_free_ring (
    .clk   (clk),
    .rst   (rst),
    .raddr (fnrd),
    .we    (r_we),
    .waddr (fnwr),
    .wdata (ptr_r[IW-1:0]),
    .rdata (ring_n)
  );

  // node memory port control
  always_comb begin
    n_re    = 1'b0;
    n_raddr = cu[IW-1:0];
    n_we    = '0;
    n_waddr = w1_addr;
    n_wnext = w1_val;
    n_wprev = w1_val;
    r_we    = 1'b0;
    unique case (state)
      S_DISP: begin
        n_re = 1'b1;
        case (cmd_r) inside
          llpm_pkg::CMD_FIRST: n_raddr = hd[IW-1:0];
          llpm_pkg::CMD_LAST,
          llpm_pkg::CMD_TRIM: n_raddr = tl[IW-1:0];
          llpm_pkg::CMD_NEXT: n_raddr = (cu == NULLP) ? hd[IW-1:0] : cu[IW-1:0];
          llpm_pkg::CMD_PREV: n_raddr = (cu == NULLP) ? tl[IW-1:0] : cu[IW-1:0];
          default: n_raddr = cu[IW-1:0];
        endcase
      end
      S_NX: begin
        n_re    = 1'b1;
        n_raddr = (cmd_r == llpm_pkg::CMD_NEXT) ? rd_next[IW-1:0] : rd_prev[IW-1:0];
      end
      S_FREE: begin
        n_re    = 1'b1;
        n_raddr = hd[IW-1:0];
      end
      S_ALLOC: begin
        n_we    = '{item: 1'b1, nxt: 1'b1, prv: 1'b1};
        n_waddr = ring_n;
        if (ln == '0) begin
          n_wnext = NULLP;
          n_wprev = NULLP;
        end else if (ins_tail) begin
          n_wnext = NULLP;
          n_wprev = tl;
        end else if (ins_head) begin
          n_wnext = hd;
          n_wprev = NULLP;
        end else if (cmd_r == llpm_pkg::CMD_INS_AFTER) begin
          n_wnext = rd_next;
          n_wprev = cu;
        end else begin
          n_wnext = cu;
          n_wprev = rd_prev;
        end
      end
      S_RM1: begin
        r_we = (nused != '0);
      end
      S_W1: begin
        n_we    = '{item: 1'b0, nxt: w1_en & ~w1_prv, prv: w1_en & w1_prv};
        n_waddr = w1_addr;
        n_wnext = w1_val;
        n_wprev = w1_val;
      end
      S_W2: begin
        n_we    = '{item: 1'b0, nxt: w2_en & ~w2_prv, prv: w2_en & w2_prv};
        n_waddr = w2_addr;
        n_wnext = w2_val;
        n_wprev = w2_val;
      end
      default: begin
        n_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      flrd  <= '0;
      flwr  <= '0;
      lused <= '0;
      fnrd  <= '0;
      fnwr  <= '0;
      nused <= '0;
      for (int i = 0; i < LISTS; i++) begin
        lhead[i]  <= NULLP;
        ltail[i]  <= NULLP;
        lcur[i]   <= NULLP;
        llen[i]   <= '0;
        lpe[i]    <= 1'b0;
        flring[i] <= LW'(i);
      end
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd_r  <= cmd;
            lr     <= lid_in;
            mr     <= mid_in;
            item_r <= item;
            stat_r <= llpm_pkg::ST_NONE;
            got_r  <= '0;
            newl_r <= '0;
            state  <= S_DISP;
          end
        end
        S_DISP: begin
          state <= S_DONE;
          case (cmd_r) inside
            llpm_pkg::CMD_CREATE: begin
              stat_r <= llpm_pkg::ST_FULL;
              if (lused < LCW'(LISTS)) begin
                flrd  <= (flrd == LW'(LISTS - 1)) ? '0 : flrd + LW'(1);
                lused <= lused + LCW'(1);
                lhead[flring[flrd]] <= NULLP;
                ltail[flring[flrd]] <= NULLP;
                lcur[flring[flrd]]  <= NULLP;
                llen[flring[flrd]]  <= '0;
                lpe[flring[flrd]]   <= 1'b0;
                stat_r <= llpm_pkg::ST_OK;
                newl_r <= flring[flrd];
                lr     <= flring[flrd];
              end
            end
            llpm_pkg::CMD_COUNT: stat_r <= llpm_pkg::ST_OK;
            llpm_pkg::CMD_FIRST, llpm_pkg::CMD_LAST: begin
              if (ln == '0) begin
                lcur[lr] <= NULLP;
              end else begin
                lcur[lr] <= (cmd_r == llpm_pkg::CMD_FIRST) ? hd : tl;
                state    <= S_GOT;
              end
            end
            llpm_pkg::CMD_NEXT: begin
              if (ln == '0) begin
                lpe[lr] <= 1'b1;
              end else if (past_tail) begin
                lpe[lr]  <= 1'b1;
                lcur[lr] <= NULLP;
              end else if (cu == NULLP) begin
                lcur[lr] <= hd;
                state    <= S_GOT;
              end else begin
                state <= S_NX;
              end
            end
            llpm_pkg::CMD_PREV: begin
              if (ln == '0) begin
                lpe[lr] <= 1'b0;
              end else if (pre_head) begin
                lpe[lr]  <= 1'b0;
                lcur[lr] <= NULLP;
              end else if (cu == NULLP) begin
                lcur[lr] <= tl;
                state    <= S_GOT;
              end else begin
                state <= S_NX;
              end
            end
            llpm_pkg::CMD_CURRENT: begin
              if (cu != NULLP && ln != '0) begin
                state <= S_GOT;
              end
            end
            llpm_pkg::CMD_INS_AFTER, llpm_pkg::CMD_INS_BEFORE,
            llpm_pkg::CMD_APPEND, llpm_pkg::CMD_PREPEND: begin
              if (nused >= NULLP) begin
                stat_r <= llpm_pkg::ST_FULL;
              end else begin
                state <= S_ALLOC;
              end
            end
            llpm_pkg::CMD_REMOVE: begin
              if (ln != '0 && cu != NULLP) begin
                ptr_r <= cu;
                state <= S_RM1;
              end
            end
            llpm_pkg::CMD_TRIM: begin
              if (ln != '0) begin
                ptr_r    <= tl;
                lcur[lr] <= tl;
                state    <= S_RM1;
              end
            end
            llpm_pkg::CMD_CONCAT: begin
              stat_r <= llpm_pkg::ST_OK;
              sav_tl <= tl;
              sav_ln <= ln;
              state  <= (lr == mr) ? S_REL : S_CAT;
            end
            llpm_pkg::CMD_FREE: begin
              stat_r <= llpm_pkg::ST_OK;
              state  <= S_FREE;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_NX: begin
          lcur[lr] <= (cmd_r == llpm_pkg::CMD_NEXT) ? rd_next : rd_prev;
          state    <= S_GOT;
        end
        S_GOT: begin
          got_r  <= rd_item;
          stat_r <= llpm_pkg::ST_OK;
          state  <= S_DONE;
        end
        S_ALLOC: begin
          fnrd     <= (fnrd == IW'(NODES - 1)) ? '0 : fnrd + IW'(1);
          nused    <= nused + PW'(1);
          lcur[lr] <= n_p;
          llen[lr] <= ln + PW'(1);
          stat_r   <= llpm_pkg::ST_OK;
          w1_en    <= 1'b0;
          w2_en    <= 1'b0;
          w1_val   <= n_p;
          w2_val   <= n_p;
          if (ln == '0) begin
            lhead[lr] <= n_p;
            ltail[lr] <= n_p;
          end else if (ins_tail) begin
            w1_en     <= (tl != NULLP);
            w1_prv    <= 1'b0;
            w1_addr   <= tl[IW-1:0];
            ltail[lr] <= n_p;
          end else if (ins_head) begin
            w1_en     <= (hd != NULLP);
            w1_prv    <= 1'b1;
            w1_addr   <= hd[IW-1:0];
            lhead[lr] <= n_p;
          end else if (cmd_r == llpm_pkg::CMD_INS_AFTER) begin
            w1_en   <= (rd_next != NULLP);
            w1_prv  <= 1'b1;
            w1_addr <= rd_next[IW-1:0];
            w2_en   <= 1'b1;
            w2_prv  <= 1'b0;
            w2_addr <= cu[IW-1:0];
          end else begin
            w1_en   <= (rd_prev != NULLP);
            w1_prv  <= 1'b0;
            w1_addr <= rd_prev[IW-1:0];
            w2_en   <= 1'b1;
            w2_prv  <= 1'b1;
            w2_addr <= cu[IW-1:0];
          end
          state <= S_W1;
        end
        S_RM1: begin
          if (cmd_r != llpm_pkg::CMD_FREE) begin
            got_r <= rd_item;
          end
          stat_r   <= llpm_pkg::ST_OK;
          llen[lr] <= ln - PW'(1);
          w1_en    <= 1'b0;
          w2_en    <= 1'b0;
          if (nused != '0) begin
            fnwr  <= (fnwr == IW'(NODES - 1)) ? '0 : fnwr + IW'(1);
            nused <= nused - PW'(1);
          end
          if (ln == PW'(1)) begin
            lhead[lr] <= NULLP;
            ltail[lr] <= NULLP;
            lcur[lr]  <= NULLP;
          end else if (ptr_r == hd) begin
            lhead[lr] <= rd_next;
            lcur[lr]  <= rd_next;
            w1_en     <= (rd_next != NULLP);
            w1_prv    <= 1'b1;
            w1_addr   <= rd_next[IW-1:0];
            w1_val    <= NULLP;
          end else if (ptr_r == tl) begin
            ltail[lr] <= rd_prev;
            lpe[lr]   <= 1'b1;
            lcur[lr]  <= (cmd_r == llpm_pkg::CMD_TRIM) ? rd_prev : NULLP;
            w1_en     <= (rd_prev != NULLP);
            w1_prv    <= 1'b0;
            w1_addr   <= rd_prev[IW-1:0];
            w1_val    <= NULLP;
          end else begin
            lcur[lr] <= rd_next;
            w1_en    <= (rd_prev != NULLP);
            w1_prv   <= 1'b0;
            w1_addr  <= rd_prev[IW-1:0];
            w1_val   <= rd_next;
            w2_en    <= (rd_next != NULLP);
            w2_prv   <= 1'b1;
            w2_addr  <= rd_next[IW-1:0];
            w2_val   <= rd_prev;
          end
          state <= S_W1;
        end
        S_W1: begin
          state <= S_W2;
        end
        S_W2: begin
          if (cmd_r == llpm_pkg::CMD_FREE) begin
            state <= S_FREE;
          end else if (cmd_r == llpm_pkg::CMD_CONCAT) begin
            state <= S_REL;
          end else begin
            state <= S_DONE;
          end
        end
        S_FREE: begin
          if (ln != '0 && hd != NULLP) begin
            ptr_r    <= hd;
            lcur[lr] <= hd;
            state    <= S_RM1;
          end else begin
            if (ln != '0) begin
              lcur[lr] <= hd;
            end
            mr    <= lr;
            state <= S_REL;
          end
        end
        S_CAT: begin
          w1_en <= 1'b0;
          w2_en <= 1'b0;
          if (sav_ln == '0) begin
            lcur[lr]  <= cu;
            lhead[lr] <= hd;
            ltail[lr] <= tl;
            llen[lr]  <= ln;
            lpe[lr]   <= pe;
          end else if (ln != '0) begin
            w1_en     <= (sav_tl != NULLP);
            w1_prv    <= 1'b0;
            w1_addr   <= sav_tl[IW-1:0];
            w1_val    <= hd;
            w2_en     <= (hd != NULLP);
            w2_prv    <= 1'b1;
            w2_addr   <= hd[IW-1:0];
            w2_val    <= sav_tl;
            ltail[lr] <= tl;
            llen[lr]  <= sav_ln + ln;
          end
          state <= S_W1;
        end
        S_REL: begin
          lhead[mr] <= NULLP;
          ltail[mr] <= NULLP;
          lcur[mr]  <= NULLP;
          llen[mr]  <= '0;
          if (lused != '0) begin
            flring[flwr] <= mr;
            flwr  <= (flwr == LW'(LISTS - 1)) ? '0 : flwr + LW'(1);
            lused <= lused - LCW'(1);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          done       <= 1'b1;
          status     <= stat_r;
          item_out   <= got_r;
          length_out <= ln;
          new_list   <= newl_r;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `LLPM_ASSERT_NEXT(a_done_single, done, !done)
  `LLPM_ASSERT_NEXT(a_take_busy, start && !busy, busy && !done)
  `LLPM_ASSERT_ALWAYS(a_nodes_bound, nused <= NULLP)
  `LLPM_ASSERT_ALWAYS(a_lists_bound, lused <= LCW'(LISTS))

endmodule

// ----- tb/tb_linked_list_pool_manager_unit.sv -----
`timescale 1ns / 100ps

module tb_linked_list_pool_manager_unit;

  localparam int NN = 64;
  localparam int NL = 8;
  localparam int NIL = NN;
  localparam logic [3:0] CMD_BAD = 4'd15;
  localparam int WD_LIMIT = 4000;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [2:0]  lid;
    logic [2:0]  oth;
    logic [31:0] itm;
  } req_t;

  typedef struct packed {
    logic [1:0]  st;
    logic [31:0] itm;
    logic [6:0]  len;
    logic [2:0]  nl;
  } resp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [3:0]  cmd = '0;
  logic [2:0]  list_id = '0;
  logic [2:0]  other_list = '0;
  logic [31:0] item = '0;
  logic        busy, done;
  logic [1:0]  status;
  logic [31:0] item_out;
  logic [6:0]  length_out;
  logic [2:0]  new_list;

  req_t  pending_reqs[$];
  resp_t expected_resps[$];
  int    errors = 0;
  int    accepted = 0;
  int    total_reqs = 0;
  int    responses = 0;
  int    full_answers = 0;
  int    idle_pct = 30;
  int    quiet_cycles = 0;

  // pool state mirror
  logic [31:0] p_item[NN];
  int p_next[NN], p_prev[NN], p_ring[NN];
  int p_rd, p_wr, p_used;
  int l_head[NL], l_tail[NL], l_cur[NL], l_len[NL];
  bit l_pe[NL];
  int h_ring[NL];
  int h_rd, h_wr, h_used;

  linked_list_pool_manager_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .list_id(list_id), .other_list(other_list), .item(item), .done(done),
    .status(status), .item_out(item_out), .length_out(length_out),
    .new_list(new_list)
  );

  always #5 clk = ~clk;

  function automatic int nxt(int n);
    return (n < NN) ? p_next[n] : NIL;
  endfunction

  function automatic int prv(int n);
    return (n < NN) ? p_prev[n] : NIL;
  endfunction

  function automatic logic [31:0] itm_of(int n);
    return (n < NN) ? p_item[n] : 32'd0;
  endfunction

  task automatic set_nxt(int n, int v);
    if (n < NN) p_next[n] = v;
  endtask

  task automatic set_prv(int n, int v);
    if (n < NN) p_prev[n] = v;
  endtask

  task automatic pool_reset();
    for (int i = 0; i < NN; i++) begin
      p_item[i] = '0; p_next[i] = 0; p_prev[i] = 0; p_ring[i] = i;
    end
    for (int i = 0; i < NL; i++) begin
      l_head[i] = NIL; l_tail[i] = NIL; l_cur[i] = NIL; l_len[i] = 0;
      l_pe[i] = 0; h_ring[i] = i;
    end
    p_rd = 0; p_wr = 0; p_used = 0; h_rd = 0; h_wr = 0; h_used = 0;
  endtask

  task automatic node_release(int n);
    if (n >= NN || p_used == 0) return;
    p_ring[p_wr] = n;
    p_wr = (p_wr + 1) % NN;
    p_used--;
  endtask

  task automatic handle_release(int l);
    l_head[l] = NIL; l_tail[l] = NIL; l_cur[l] = NIL; l_len[l] = 0;
    if (h_used == 0) return;
    h_ring[h_wr] = l;
    h_wr = (h_wr + 1) % NL;
    h_used--;
  endtask

  task automatic tail_link(int l, int n);
    set_prv(n, l_tail[l]);
    set_nxt(l_tail[l], n);
    l_tail[l] = n;
  endtask

  task automatic head_link(int l, int n);
    set_nxt(n, l_head[l]);
    set_prv(l_head[l], n);
    l_head[l] = n;
  endtask

  // mode 0 after cursor, 1 before cursor, 2 append, 3 prepend
  task automatic list_insert(int l, logic [31:0] v, int mode, output bit ok);
    int c, n, o;
    c = l_cur[l];
    ok = 0;
    if (p_used >= NN) return;
    n = p_ring[p_rd];
    if (n >= NN) n = 0;
    p_rd = (p_rd + 1) % NN;
    p_used++;
    p_item[n] = v; p_next[n] = NIL; p_prev[n] = NIL;
    if (l_len[l] == 0) begin
      l_head[l] = n; l_tail[l] = n;
    end else if (mode == 2) begin
      tail_link(l, n);
    end else if (mode == 3) begin
      head_link(l, n);
    end else if (mode == 0) begin
      if (c == l_tail[l] || (c == NIL && l_pe[l])) tail_link(l, n);
      else if (c == NIL) head_link(l, n);
      else begin
        o = nxt(c);
        set_nxt(n, o); set_prv(n, c); set_prv(o, n); set_nxt(c, n);
      end
    end else begin
      if (c == l_head[l] || (c == NIL && !l_pe[l])) head_link(l, n);
      else if (c == NIL) tail_link(l, n);
      else begin
        o = prv(c);
        set_nxt(n, c); set_prv(n, o); set_nxt(o, n); set_prv(c, n);
      end
    end
    l_cur[l] = n;
    l_len[l]++;
    ok = 1;
  endtask

  task automatic cursor_remove(int l, output bit ok, output logic [31:0] v);
    int c, a, b;
    c = l_cur[l];
    ok = 0;
    v = '0;
    if (l_len[l] == 0 || c == NIL) return;
    v = itm_of(c);
    if (l_len[l] == 1) begin
      l_head[l] = NIL; l_tail[l] = NIL;
      node_release(c);
      l_cur[l] = NIL;
    end else if (c == l_head[l]) begin
      l_head[l] = nxt(c);
      set_prv(l_head[l], NIL);
      node_release(c);
      l_cur[l] = l_head[l];
    end else if (c == l_tail[l]) begin
      l_tail[l] = prv(c);
      set_nxt(l_tail[l], NIL);
      node_release(c);
      l_pe[l] = 1;
      l_cur[l] = NIL;
    end else begin
      a = nxt(c); b = prv(c);
      set_nxt(b, a);
      node_release(c);
      l_cur[l] = a;
      set_prv(a, b);
    end
    l_len[l]--;
    ok = 1;
  endtask

  task automatic predict_request(req_t r);
    int l, m, c, h;
    bit ok;
    logic [31:0] v;
    resp_t e;
    l = int'(r.lid); m = int'(r.oth);
    e = '0;
    e.st = llpm_pkg::ST_NONE;
    case (r.cmd)
      llpm_pkg::CMD_CREATE: begin
        e.st = llpm_pkg::ST_FULL;
        if (h_used < NL) begin
          h = h_ring[h_rd];
          h_rd = (h_rd + 1) % NL;
          h_used++;
          l_head[h] = NIL; l_tail[h] = NIL; l_cur[h] = NIL;
          l_len[h] = 0; l_pe[h] = 0;
          e.st = llpm_pkg::ST_OK; e.nl = 3'(h); l = h;
        end
      end
      llpm_pkg::CMD_COUNT: e.st = llpm_pkg::ST_OK;
      llpm_pkg::CMD_FIRST, llpm_pkg::CMD_LAST: begin
        if (l_len[l] == 0) l_cur[l] = NIL;
        else begin
          l_cur[l] = (r.cmd == llpm_pkg::CMD_FIRST) ? l_head[l] : l_tail[l];
          e.itm = itm_of(l_cur[l]); e.st = llpm_pkg::ST_OK;
        end
      end
      llpm_pkg::CMD_NEXT: begin
        c = l_cur[l];
        if (l_len[l] == 0) l_pe[l] = 1;
        else if (c == l_tail[l] || (c == NIL && l_pe[l])) begin
          l_pe[l] = 1; l_cur[l] = NIL;
        end else begin
          l_cur[l] = (c == NIL) ? l_head[l] : nxt(c);
          e.itm = itm_of(l_cur[l]); e.st = llpm_pkg::ST_OK;
        end
      end
      llpm_pkg::CMD_PREV: begin
        c = l_cur[l];
        if (l_len[l] == 0) l_pe[l] = 0;
        else if (c == l_head[l] || (c == NIL && !l_pe[l])) begin
          l_pe[l] = 0; l_cur[l] = NIL;
        end else begin
          l_cur[l] = (c == NIL) ? l_tail[l] : prv(c);
          e.itm = itm_of(l_cur[l]); e.st = llpm_pkg::ST_OK;
        end
      end
      llpm_pkg::CMD_CURRENT: begin
        if (l_cur[l] != NIL && l_len[l] != 0) begin
          e.itm = itm_of(l_cur[l]); e.st = llpm_pkg::ST_OK;
        end
      end
      llpm_pkg::CMD_INS_AFTER, llpm_pkg::CMD_INS_BEFORE,
      llpm_pkg::CMD_APPEND, llpm_pkg::CMD_PREPEND: begin
        list_insert(l, r.itm, int'(r.cmd) - int'(llpm_pkg::CMD_INS_AFTER), ok);
        e.st = ok ? llpm_pkg::ST_OK : llpm_pkg::ST_FULL;
      end
      llpm_pkg::CMD_REMOVE: begin
        cursor_remove(l, ok, v);
        e.itm = v;
        if (ok) e.st = llpm_pkg::ST_OK;
      end
      llpm_pkg::CMD_TRIM: begin
        if (l_len[l] != 0) begin
          l_cur[l] = l_tail[l];
          cursor_remove(l, ok, v);
          e.itm = v;
          if (l_len[l] != 0) l_cur[l] = l_tail[l];
          e.st = llpm_pkg::ST_OK;
        end
      end
      llpm_pkg::CMD_CONCAT: begin
        e.st = llpm_pkg::ST_OK;
        if (l == m) handle_release(m);
        else if (l_len[l] == 0) begin
          l_cur[l] = l_cur[m]; l_head[l] = l_head[m]; l_tail[l] = l_tail[m];
          l_len[l] = l_len[m]; l_pe[l] = l_pe[m];
          handle_release(m);
        end else if (l_len[m] == 0) handle_release(m);
        else begin
          set_nxt(l_tail[l], l_head[m]);
          set_prv(l_head[m], l_tail[l]);
          l_tail[l] = l_tail[m];
          l_len[l] = l_len[l] + l_len[m];
          handle_release(m);
        end
      end
      llpm_pkg::CMD_FREE: begin
        for (int k = 0; k < NN && l_len[l] != 0; k++) begin
          l_cur[l] = l_head[l];
          cursor_remove(l, ok, v);
          if (!ok) break;
        end
        handle_release(l);
        e.st = llpm_pkg::ST_OK;
      end
      default: ;
    endcase
    e.len = 7'(l_len[l]);
    expected_resps.push_back(e);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    errors++;
  endtask

  function automatic req_t mk(logic [3:0] c, int l, int o, logic [31:0] v);
    req_t r;
    r.cmd = c; r.lid = 3'(l); r.oth = 3'(o); r.itm = v;
    return r;
  endfunction

  function automatic req_t random_req();
    int w;
    logic [3:0] c;
    w = $urandom_range(99);
    if (w < 4) c = llpm_pkg::CMD_CREATE;
    else if (w < 30)
      c = 4'($urandom_range(llpm_pkg::CMD_INS_AFTER, llpm_pkg::CMD_PREPEND));
    else if (w < 60) c = 4'($urandom_range(llpm_pkg::CMD_COUNT, llpm_pkg::CMD_CURRENT));
    else if (w < 78) c = (w < 70) ? llpm_pkg::CMD_REMOVE : llpm_pkg::CMD_TRIM;
    else if (w < 85) c = llpm_pkg::CMD_CONCAT;
    else if (w < 91) c = llpm_pkg::CMD_FREE;
    else if (w < 93) c = CMD_BAD;
    else c = llpm_pkg::CMD_APPEND;
    return mk(c, $urandom_range(NL - 1), $urandom_range(NL - 1), $urandom());
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_request({cmd, list_id, other_list, item});
        accepted++;
      end
      if (!start || !busy) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
          req_t r;
          r = pending_reqs.pop_front();
          cmd <= r.cmd; list_id <= r.lid; other_list <= r.oth; item <= r.itm;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (accepted < total_reqs / 3) idle_pct = 30;
      else if (accepted < 2 * total_reqs / 3) idle_pct = 62;
      else idle_pct = 0;
    end
  end

  // response monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      resp_t e;
      responses++;
      if (expected_resps.size() == 0) begin
        report_mismatch("unexpected response status", 32'(status), 32'd0);
      end else begin
        e = expected_resps.pop_front();
        if (e.st == llpm_pkg::ST_FULL) full_answers++;
        if (status !== e.st) report_mismatch("status", 32'(status), 32'(e.st));
        if (item_out !== e.itm) report_mismatch("item_out", item_out, e.itm);
        if (length_out !== e.len)
          report_mismatch("length_out", 32'(length_out), 32'(e.len));
        if (new_list !== e.nl) report_mismatch("new_list", 32'(new_list), 32'(e.nl));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("timeout with %0d responses outstanding", expected_resps.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    pool_reset();
    for (int i = 0; i < NL + 1; i++) pending_reqs.push_back(mk(llpm_pkg::CMD_CREATE, 0, 0, 0));
    pending_reqs.push_back(mk(llpm_pkg::CMD_COUNT, 7, 0, 0));
    pending_reqs.push_back(mk(llpm_pkg::CMD_FIRST, 0, 0, 0));
    pending_reqs.push_back(mk(llpm_pkg::CMD_LAST, 0, 0, 0));
    pending_reqs.push_back(mk(llpm_pkg::CMD_NEXT, 0, 0, 0));
    pending_reqs.push_back(mk(llpm_pkg::CMD_PREV, 0, 0, 0));
    pending_reqs.push_back(mk(llpm_pkg::CMD_CURRENT, 0, 0, 0));
    pending_reqs.push_back(mk(llpm_pkg::CMD_INS_AFTER, 1, 0, 32'hffff_ffff));
    pending_reqs.push_back(mk(llpm_pkg::CMD_APPEND, 1, 0, 32'h0));
    pending_reqs.push_back(mk(llpm_pkg::CMD_PREPEND, 1, 0, 32'ha5a5_5a5a));
    pending_reqs.push_back(mk(llpm_pkg::CMD_INS_BEFORE, 1, 0, 32'h5a5a_a5a5));
    pending_reqs.push_back(mk(llpm_pkg::CMD_NEXT, 1, 0, 0));
    pending_reqs.push_back(mk(llpm_pkg::CMD_PREV, 1, 0, 0));
    pending_reqs.push_back(mk(llpm_pkg::CMD_REMOVE, 1, 0, 0));
    pending_reqs.push_back(mk(llpm_pkg::CMD_TRIM, 1, 0, 0));
    pending_reqs.push_back(mk(llpm_pkg::CMD_APPEND, 2, 0, 32'h1234_5678));
    pending_reqs.push_back(mk(llpm_pkg::CMD_CONCAT, 1, 2, 0));
    pending_reqs.push_back(mk(llpm_pkg::CMD_CONCAT, 3, 3, 0));
    pending_reqs.push_back(mk(llpm_pkg::CMD_FREE, 1, 0, 0));
    pending_reqs.push_back(mk(CMD_BAD, 7, 7, 32'hffff_ffff));
    // fill the pool to exhaustion, then reclaim it
    for (int i = 0; i < NN + 2; i++)
      pending_reqs.push_back(mk(llpm_pkg::CMD_APPEND, 4, 0, $urandom()));
    pending_reqs.push_back(mk(llpm_pkg::CMD_FREE, 4, 0, 0));
    for (int i = 0; i < 1250; i++) begin
      if ($urandom_range(99) < 70) begin
        int l, n;
        l = $urandom_range(NL - 1);
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++)
          pending_reqs.push_back(mk(4'($urandom_range(llpm_pkg::CMD_INS_AFTER,
                                                      llpm_pkg::CMD_PREPEND)),
                                    l, 0, $urandom()));
        for (int k = 0; k < n; k++)
          pending_reqs.push_back(mk(4'($urandom_range(llpm_pkg::CMD_FIRST,
                                                      llpm_pkg::CMD_CURRENT)),
                                    l, 0, 0));
        i += 2 * n - 1;
      end else begin
        pending_reqs.push_back(random_req());
      end
    end
    total_reqs = pending_reqs.size();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    wait (pending_reqs.size() == 0 && !start && expected_resps.size() == 0);
    repeat (250) @(posedge clk);
    $display("covered %0d requests and %0d responses, %0d of them pool-exhausted",
             accepted, responses, full_answers);
    if (errors == 0 && expected_resps.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
